// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the timer slot table modules
// Both macros sample on clk and are disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge
`define TST_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent
`define TST_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== src/tst_pkg.sv =====
// ----------------------------------------------------------------------------
// tst_pkg
// Codes, constants and controller/datapath interface types of the timer
// slot table.
// ----------------------------------------------------------------------------
package tst_pkg;

    // Command codes (codes above CMD_SCAN are rejected)
    localparam logic [2:0] CMD_START   = 3'd0;
    localparam logic [2:0] CMD_ARM     = 3'd1;
    localparam logic [2:0] CMD_DISARM  = 3'd2;
    localparam logic [2:0] CMD_RELEASE = 3'd3;
    localparam logic [2:0] CMD_SCAN    = 3'd4;

    // Result kinds
    localparam logic [1:0] KIND_ANSWER  = 2'd0;
    localparam logic [1:0] KIND_FIRE    = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    // Result status
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BAD  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic [9:0]  MS_PER_S  = 10'd1000;
    localparam logic [25:0] REM_MAX   = 26'd65535000;
    localparam int          MAX_FIRES = 32;
    localparam int          FIRE_W    = 6;

    // Controller to datapath commands
    typedef struct packed {
        logic       capture;
        logic       set_status;
        logic [1:0] status;
        logic       stack_read;
        logic       alloc;
        logic       owner_read;
        logic       apply;
        logic       scan_init;
        logic       scan_read;
        logic       scan_sub;
        logic       scan_upd;
        logic       load_answer;
        logic       load_fire;
        logic       load_summary;
    } ctl_t;

    // Datapath to controller status
    typedef struct packed {
        logic [2:0] cmd;
        logic       uid_zero;
        logic       slot_bad;
        logic       stack_empty;
        logic       owner_match;
        logic       fire;
        logic       fires_full;
        logic       scan_last;
        logic       out_free;
    } stat_t;

endpackage

// ===== src/tst_ram.sv =====
// ----------------------------------------------------------------------------
// tst_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module tst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/tst_ctrl.sv =====
// ----------------------------------------------------------------------------
// tst_ctrl
// Command sequencer of the timer slot table: decodes each transaction,
// steps the table lookups and walks the slots during a scan.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tst_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  tst_pkg::stat_t stat,
    output tst_pkg::ctl_t  ctl
);

    import tst_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_DECODE   = 9'b000000010,
        S_STACK    = 9'b000000100,
        S_OWNER    = 9'b000001000,
        S_ANSWER   = 9'b000010000,
        S_SCAN_RD  = 9'b000100000,
        S_SCAN_SUB = 9'b001000000,
        S_SCAN_UPD = 9'b010000000,
        S_SUMMARY  = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    ctl.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                priority if (stat.cmd == CMD_START)
                begin
                    if (stat.uid_zero)
                    begin
                        ctl.set_status = 1'b1;
                        ctl.status     = ST_BAD;
                        state_next     = S_ANSWER;
                    end
                    else if (stat.stack_empty)
                    begin
                        ctl.set_status = 1'b1;
                        ctl.status     = ST_FULL;
                        state_next     = S_ANSWER;
                    end
                    else
                    begin
                        ctl.stack_read = 1'b1;
                        state_next     = S_STACK;
                    end
                end
                else if (stat.cmd == CMD_ARM || stat.cmd == CMD_DISARM
                         || stat.cmd == CMD_RELEASE)
                begin
                    if (stat.uid_zero || stat.slot_bad)
                    begin
                        ctl.set_status = 1'b1;
                        ctl.status     = ST_BAD;
                        state_next     = S_ANSWER;
                    end
                    else
                    begin
                        ctl.owner_read = 1'b1;
                        state_next     = S_OWNER;
                    end
                end
                else if (stat.cmd == CMD_SCAN)
                begin
                    ctl.scan_init = 1'b1;
                    state_next    = S_SCAN_RD;
                end
                else
                begin
                    ctl.set_status = 1'b1;
                    ctl.status     = ST_BAD;
                    state_next     = S_ANSWER;
                end
            end
            S_STACK:
            begin
                ctl.alloc      = 1'b1;
                ctl.set_status = 1'b1;
                ctl.status     = ST_OK;
                state_next     = S_ANSWER;
            end
            S_OWNER:
            begin
                ctl.set_status = 1'b1;
                ctl.status     = stat.owner_match ? ST_OK : ST_BAD;
                ctl.apply      = stat.owner_match;
                state_next     = S_ANSWER;
            end
            S_ANSWER:
            begin
                if (stat.out_free)
                begin
                    ctl.load_answer = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_SCAN_RD:
            begin
                ctl.scan_read = 1'b1;
                state_next    = S_SCAN_SUB;
            end
            S_SCAN_SUB:
            begin
                ctl.scan_sub = 1'b1;
                state_next   = S_SCAN_UPD;
            end
            S_SCAN_UPD:
            begin
                // hold while a fire waits for the output register
                if (!(stat.fire && !stat.fires_full && !stat.out_free))
                begin
                    ctl.scan_upd  = 1'b1;
                    ctl.load_fire = stat.fire && !stat.fires_full;
                    state_next    = stat.scan_last ? S_SUMMARY : S_SCAN_RD;
                end
            end
            S_SUMMARY:
            begin
                if (stat.out_free)
                begin
                    ctl.load_summary = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `TST_ASSERT_IMPL(a_load_when_free,
        ctl.load_answer || ctl.load_fire || ctl.load_summary, stat.out_free,
        "result loaded while output register is occupied")
    `TST_ASSERT(a_single_load,
        $countones({ctl.load_answer, ctl.load_fire, ctl.load_summary}) <= 1,
        "more than one result loaded in a cycle")
    `TST_ASSERT_IMPL(a_capture_only_idle, ctl.capture, s_tready && s_tvalid,
        "capture outside an accepted transaction")

endmodule

// ===== src/tst_dp.sv =====
// ----------------------------------------------------------------------------
// tst_dp
// Datapath of the timer slot table: owner, deadline and free-slot memories,
// deadline arithmetic, scan minimum tracking and the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tst_dp #(
    parameter int SLOTS = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [103:0]   s_tdata,
    input  logic [2:0]     s_tuser,
    output logic [71:0]    m_tdata,
    output logic [1:0]     m_tuser,
    output logic           m_tlast,
    output logic           m_tvalid,
    input  logic           m_tready,
    input  tst_pkg::ctl_t  ctl,
    output tst_pkg::stat_t stat
);

    import tst_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);

    // Captured transaction
    logic [2:0]       cmd_reg;
    logic [4:0]       slot_reg;
    logic [30:0]      uid_reg;
    logic [47:0]      now_reg;
    logic [25:0]      prod_reg;
    logic [1:0]       status_reg;
    logic [4:0]       ans_slot_reg;

    // Table bookkeeping
    logic [CNT_W-1:0] free_cnt_reg;
    logic [SLOTS-1:0] own_vld_reg;
    logic [SLOTS-1:0] dl_vld_reg;
    logic [SLOTS-1:0] stk_vld_reg;
    logic             own_rvld_reg;
    logic             dl_rvld_reg;
    logic             stk_rvld_reg;
    logic [IDX_W-1:0] stk_raddr_reg;

    // Scan state
    logic [IDX_W-1:0]  scan_idx_reg;
    logic [FIRE_W-1:0] fire_cnt_reg;
    logic              fire_reg;
    logic              pend_reg;
    logic [47:0]       diff_reg;
    logic [30:0]       scan_owner_reg;
    logic              have_reg;
    logic [4:0]        best_slot_reg;
    logic [30:0]       best_owner_reg;
    logic [25:0]       best_rem_reg;

    // Output register
    logic        out_valid_reg;
    logic [1:0]  out_kind_reg;
    logic [1:0]  out_status_reg;
    logic [4:0]  out_slot_reg;
    logic [30:0] out_owner_reg;
    logic [25:0] out_rem_reg;
    logic        out_found_reg;
    logic        out_last_reg;

    // Memory ports
    logic             own_we;
    logic [IDX_W-1:0] own_waddr;
    logic [30:0]      own_wdata;
    logic             own_re;
    logic [IDX_W-1:0] own_raddr;
    logic [30:0]      own_rdata;
    logic             dl_we;
    logic [47:0]      dl_wdata;
    logic [47:0]      dl_rdata;
    logic             stk_we;
    logic [IDX_W-1:0] stk_waddr;
    logic [IDX_W-1:0] stk_raddr;
    logic [IDX_W-1:0] stk_rdata;

    logic [IDX_W-1:0] slot_idx;
    logic [IDX_W-1:0] alloc_slot;
    logic [30:0]      owner_val;
    logic [47:0]      dl_val;
    logic [48:0]      arm_sum;
    logic [47:0]      arm_dl;
    logic [48:0]      scan_diff;
    logic             scan_act;
    logic [25:0]      scan_rem;
    logic             better;
    logic             push_ok;

    assign slot_idx   = IDX_W'(slot_reg);
    assign alloc_slot = stk_rvld_reg ? stk_rdata : stk_raddr_reg;
    assign owner_val  = own_rvld_reg ? own_rdata : '0;
    assign dl_val     = dl_rvld_reg ? dl_rdata : '0;
    assign push_ok    = free_cnt_reg < CNT_W'(SLOTS);

    // Arm deadline: now plus timeout, saturating at the top of the time range
    assign arm_sum = {1'b0, now_reg} + {23'b0, prod_reg};
    assign arm_dl  = arm_sum[48] ? '1 : arm_sum[47:0];

    // Borrow out of deadline minus now means the slot has expired
    assign scan_act  = (owner_val != '0) && (dl_val != '0);
    assign scan_diff = {1'b0, dl_val} - {1'b0, now_reg};
    assign scan_rem  = (diff_reg > {22'b0, REM_MAX}) ? REM_MAX : diff_reg[25:0];
    assign better    = pend_reg && (!have_reg || scan_rem < best_rem_reg);

    assign own_we    = ctl.alloc || (ctl.apply && cmd_reg == CMD_RELEASE);
    assign own_waddr = ctl.alloc ? alloc_slot : slot_idx;
    assign own_wdata = ctl.alloc ? uid_reg : '0;
    assign own_re    = ctl.owner_read || ctl.scan_read;
    assign own_raddr = ctl.owner_read ? slot_idx : scan_idx_reg;

    assign dl_we    = ctl.apply;
    assign dl_wdata = (cmd_reg == CMD_ARM) ? arm_dl : '0;

    assign stk_we    = ctl.apply && cmd_reg == CMD_RELEASE && push_ok;
    assign stk_waddr = IDX_W'(free_cnt_reg);
    assign stk_raddr = IDX_W'(free_cnt_reg - CNT_W'(1));

    tst_ram #(
        .WIDTH (31),
        .DEPTH (SLOTS)
    ) u_owner_ram (
        .clk   (clk),
        .we    (own_we),
        .waddr (own_waddr),
        .wdata (own_wdata),
        .re    (own_re),
        .raddr (own_raddr),
        .rdata (own_rdata)
    );

    tst_ram #(
        .WIDTH (48),
        .DEPTH (SLOTS)
    ) u_deadline_ram (
        .clk   (clk),
        .we    (dl_we),
        .waddr (slot_idx),
        .wdata (dl_wdata),
        .re    (ctl.scan_read),
        .raddr (scan_idx_reg),
        .rdata (dl_rdata)
    );

    tst_ram #(
        .WIDTH (IDX_W),
        .DEPTH (SLOTS)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (slot_idx),
        .re    (ctl.stack_read),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // Control state: fill count, per-entry written flags, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_cnt_reg  <= CNT_W'(SLOTS);
            own_vld_reg   <= '0;
            dl_vld_reg    <= '0;
            stk_vld_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.alloc)
            begin
                free_cnt_reg <= free_cnt_reg - CNT_W'(1);
            end
            else if (stk_we)
            begin
                free_cnt_reg <= free_cnt_reg + CNT_W'(1);
            end
            if (own_we)
            begin
                own_vld_reg[own_waddr] <= 1'b1;
            end
            if (dl_we)
            begin
                dl_vld_reg[slot_idx] <= 1'b1;
            end
            if (stk_we)
            begin
                stk_vld_reg[stk_waddr] <= 1'b1;
            end
            if (ctl.load_answer || ctl.load_fire || ctl.load_summary)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg      <= s_tuser;
            slot_reg     <= s_tdata[4:0];
            uid_reg      <= s_tdata[35:5];
            now_reg      <= s_tdata[99:52];
            prod_reg     <= 26'(s_tdata[51:36]) * 26'(MS_PER_S);
            ans_slot_reg <= (s_tuser == CMD_START) ? 5'd0 : s_tdata[4:0];
        end
        if (ctl.set_status)
        begin
            status_reg <= ctl.status;
        end
        if (ctl.alloc)
        begin
            ans_slot_reg <= 5'(alloc_slot);
        end
        if (own_re)
        begin
            own_rvld_reg <= own_vld_reg[own_raddr];
        end
        if (ctl.scan_read)
        begin
            dl_rvld_reg <= dl_vld_reg[scan_idx_reg];
        end
        if (ctl.stack_read)
        begin
            stk_rvld_reg  <= stk_vld_reg[stk_raddr];
            stk_raddr_reg <= stk_raddr;
        end
        if (ctl.scan_init)
        begin
            scan_idx_reg <= '0;
            fire_cnt_reg <= '0;
            have_reg     <= 1'b0;
        end
        if (ctl.scan_sub)
        begin
            fire_reg       <= scan_act && scan_diff[48];
            pend_reg       <= scan_act && !scan_diff[48];
            diff_reg       <= scan_diff[47:0];
            scan_owner_reg <= owner_val;
        end
        if (ctl.scan_upd)
        begin
            scan_idx_reg <= scan_idx_reg + IDX_W'(1);
            if (better)
            begin
                have_reg       <= 1'b1;
                best_slot_reg  <= 5'(scan_idx_reg);
                best_owner_reg <= scan_owner_reg;
                best_rem_reg   <= scan_rem;
            end
        end
        if (ctl.load_fire)
        begin
            fire_cnt_reg <= fire_cnt_reg + FIRE_W'(1);
        end

        priority if (ctl.load_answer)
        begin
            out_kind_reg   <= KIND_ANSWER;
            out_status_reg <= status_reg;
            out_slot_reg   <= ans_slot_reg;
            out_owner_reg  <= uid_reg;
            out_rem_reg    <= '0;
            out_found_reg  <= 1'b0;
            out_last_reg   <= 1'b1;
        end
        else if (ctl.load_fire)
        begin
            out_kind_reg   <= KIND_FIRE;
            out_status_reg <= ST_OK;
            out_slot_reg   <= 5'(scan_idx_reg);
            out_owner_reg  <= scan_owner_reg;
            out_rem_reg    <= '0;
            out_found_reg  <= 1'b0;
            out_last_reg   <= 1'b0;
        end
        else if (ctl.load_summary)
        begin
            out_kind_reg   <= KIND_SUMMARY;
            out_status_reg <= ST_OK;
            out_slot_reg   <= have_reg ? best_slot_reg : 5'd0;
            out_owner_reg  <= have_reg ? best_owner_reg : '0;
            out_rem_reg    <= have_reg ? best_rem_reg : '0;
            out_found_reg  <= have_reg;
            out_last_reg   <= 1'b1;
        end
        else
        begin
            // hold
        end
    end

    assign stat.cmd         = cmd_reg;
    assign stat.uid_zero    = (uid_reg == '0);
    assign stat.slot_bad    = ({27'b0, slot_reg} >= 32'(SLOTS));
    assign stat.stack_empty = (free_cnt_reg == '0);
    assign stat.owner_match = (owner_val == uid_reg);
    assign stat.fire        = fire_reg;
    assign stat.fires_full  = (fire_cnt_reg == FIRE_W'(MAX_FIRES));
    assign stat.scan_last   = (scan_idx_reg == IDX_W'(SLOTS - 1));
    assign stat.out_free    = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {7'b0, out_found_reg, out_rem_reg, out_owner_reg,
                       out_slot_reg, out_status_reg};

    `TST_ASSERT(a_cnt_range, free_cnt_reg <= CNT_W'(SLOTS),
        "free slot count above table size")
    `TST_ASSERT_IMPL(a_alloc_nonempty, ctl.alloc, free_cnt_reg != '0,
        "slot allocated from an empty free stack")
    `TST_ASSERT_IMPL(a_fire_not_last, out_valid_reg && out_kind_reg == KIND_FIRE,
        !out_last_reg && out_status_reg == ST_OK,
        "fire result marked last or with error status")
    `TST_ASSERT_IMPL(a_fire_cap, ctl.load_fire,
        fire_cnt_reg < FIRE_W'(MAX_FIRES),
        "fire reported beyond the per-scan limit")

endmodule

// ===== src/timer_slot_table.sv =====
// ----------------------------------------------------------------------------
// timer_slot_table
// Table of timer slots with owner ids and deadlines, a LIFO free-slot stack
// and a scan that reports expired slots and the nearest pending deadline.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_axis    in         tuser: cmd; tdata: slot, user_id, seconds, now_ms
//  m_axis    out        tuser: kind; tdata: status, slot_out, owner_out,
//                       remaining_ms, found; tlast: last
//
//  A command goes from accept through decode and a registered read of the
//  owner or free-stack memory to its result; one that is rejected before
//  any read (zero owner, slot out of range, full table, unknown code) skips the read.
//  A scan visits the slots in turn with one memory read, one subtract and one
//  compare stage per slot, and holds while a result waits on a stalled output.
//  Reset is immediate: per-entry written flags stand in for cleared memories.
// ----------------------------------------------------------------------------
module timer_slot_table #(
    parameter int SLOTS = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,   // slot, user_id, seconds, now_ms, pad
    input  logic [2:0]   s_tuser,   // cmd
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata,   // status, slot_out, owner_out, remaining_ms, found, pad
    output logic [1:0]   m_tuser,   // kind
    output logic         m_tlast
);

    import tst_pkg::*;

    ctl_t  ctl;
    stat_t stat;

    tst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .ctl      (ctl)
    );

    tst_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .ctl      (ctl),
        .stat     (stat)
    );

endmodule
